### design/pperim_pkg.sv
// shared constants and types for the polygon perimeter filter
package pperim_pkg;

    localparam int COORD_W    = 16;
    localparam int SUM_W      = 27;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int ROOT_W     = DIFF_W;
    localparam int RAD_W      = 2 * DIFF_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ITER_CNT_W = $clog2(ROOT_W);
    localparam int IN_DATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = SUM_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_EN = 1'b1;

    // tuser bit positions on the result channel
    localparam int USER_SELECTED  = 0;
    localparam int USER_SATURATED = 1;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

### design/pperim_sqrt.sv
// iterative restoring square root, one root bit per cycle
module pperim_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pperim_pkg::RAD_W-1:0]   radicand,
    output logic [pperim_pkg::ROOT_W-1:0]  root,
    output pperim_pkg::sqrt_status_t       status
);

    logic [pperim_pkg::RAD_W-1:0]      rad_reg;
    logic [pperim_pkg::REM_W-1:0]      rem_reg;
    logic [pperim_pkg::ROOT_W-1:0]     root_reg;
    logic [pperim_pkg::ITER_CNT_W-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [pperim_pkg::REM_W+1:0] shifted;
    logic [pperim_pkg::REM_W+1:0] trial;
    logic                         fits;

    // bring down the next two radicand bits and try root*4+1
    assign shifted = {rem_reg, rad_reg[pperim_pkg::RAD_W-1 -: 2]};
    assign trial   = {{(pperim_pkg::REM_W-pperim_pkg::ROOT_W){1'b0}}, root_reg, 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= pperim_pkg::ITER_CNT_W'(pperim_pkg::ROOT_W - 1);
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[pperim_pkg::RAD_W-3:0], 2'b00};
                if (fits) begin
                    rem_reg  <= pperim_pkg::REM_W'(shifted - trial);
                    root_reg <= {root_reg[pperim_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= pperim_pkg::REM_W'(shifted);
                    root_reg <= {root_reg[pperim_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("square root restarted while busy");

endmodule

### design/polygon_perimeter_filter_top.sv
// top level of the polygon perimeter filter
// Vertices arrive one word at a time as signed x/y coordinates with four
// fractional bits; tlast marks the final vertex of a polygon. Every edge,
// including the closing edge back to the first vertex, adds the floor square
// root of dx*dx + dy*dy to a running sum that sticks at its maximum. On the
// final vertex one result word leaves with the perimeter, a selected flag
// (filter off, or perimeter strictly above the threshold) and a saturated
// flag. The first vertex of a longer polygon only opens it and leaves the
// block ready. Each further vertex runs one edge through the shared square
// root unit: accepting the vertex, the coordinate differences, the squares
// on the single multiplier, starting the root, the root iterations (one
// result bit each), seeing the root unit finish and accumulating, and only
// then is the next vertex taken; a final vertex runs its own edge and the
// closing edge, then loads the result word, later while an earlier result
// word still waits on the output. A polygon of one vertex gives perimeter 0.
// The block is not ready while an edge is in flight, but it takes the next
// vertex while a result word still waits on the output. Configuration
// writes take effect at once, so they belong where the block is idle.
module polygon_perimeter_filter_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [pperim_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pperim_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // vertex input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pperim_pkg::IN_DATA_W-1:0]    s_tdata,   // vertex_x, vertex_y
    input  logic                                s_tlast,   // last_vertex

    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pperim_pkg::OUT_DATA_W-1:0]   m_tdata,   // perimeter, zero pad
    output logic [pperim_pkg::OUT_USER_W-1:0]   m_tuser    // selected, saturated
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a vertex
    localparam logic [2:0] ST_DIFF = 3'd1;  // absolute coordinate differences
    localparam logic [2:0] ST_SQX  = 3'd2;  // dx squared
    localparam logic [2:0] ST_SQY  = 3'd3;  // dy squared
    localparam logic [2:0] ST_GO   = 3'd4;  // sum of squares into the root unit
    localparam logic [2:0] ST_SQRT = 3'd5;  // root iterations
    localparam logic [2:0] ST_ACC  = 3'd6;  // add edge length to the sum
    localparam logic [2:0] ST_OUT  = 3'd7;  // hand the result word over

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [pperim_pkg::SUM_W-1:0] threshold_reg;
    logic                         filter_en_reg;

    // polygon state
    logic [pperim_pkg::COORD_W-1:0] first_x_reg, first_y_reg;
    logic [pperim_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [pperim_pkg::SUM_W-1:0]   sum_reg;
    logic                           open_reg;
    logic                           last_reg;     // current vertex closes the polygon
    logic                           closing_reg;  // edge in flight is the closing edge

    // edge operands and datapath
    logic [pperim_pkg::COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [pperim_pkg::DIFF_W-1:0]  dx_reg, dy_reg;
    logic [pperim_pkg::RAD_W-1:0]   sqx_reg, prod_reg;

    // result word
    logic                         m_valid_reg;
    logic [pperim_pkg::SUM_W-1:0] perim_reg;
    logic                         selected_reg;
    logic                         saturated_reg;

    logic                           s_accept;
    logic                           out_free;
    logic [pperim_pkg::COORD_W-1:0] in_x, in_y;
    logic [pperim_pkg::DIFF_W-1:0]  diff_x, diff_y;
    logic [pperim_pkg::DIFF_W-1:0]  mul_op;
    logic [pperim_pkg::RAD_W-1:0]   mul_out;
    logic [pperim_pkg::RAD_W-1:0]   radicand;
    logic [pperim_pkg::ROOT_W-1:0]  root;
    logic [pperim_pkg::SUM_W:0]     sum_wide;
    logic [pperim_pkg::SUM_W-1:0]   sum_sat;
    pperim_pkg::sqrt_status_t       sq_stat;

    assign in_x     = s_tdata[pperim_pkg::COORD_W-1:0];
    assign in_y     = s_tdata[2*pperim_pkg::COORD_W-1:pperim_pkg::COORD_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // absolute differences on sign-extended coordinates
    function automatic logic [pperim_pkg::DIFF_W-1:0] abs_diff(
        input logic [pperim_pkg::COORD_W-1:0] a,
        input logic [pperim_pkg::COORD_W-1:0] b
    );
        logic [pperim_pkg::DIFF_W-1:0] d;
        d = {a[pperim_pkg::COORD_W-1], a} - {b[pperim_pkg::COORD_W-1], b};
        return d[pperim_pkg::DIFF_W-1] ? (pperim_pkg::DIFF_W'(0) - d) : d;
    endfunction

    assign diff_x = abs_diff(ax_reg, bx_reg);
    assign diff_y = abs_diff(ay_reg, by_reg);

    // the one multiplier, squaring dx then dy
    assign mul_op  = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign mul_out = pperim_pkg::RAD_W'(mul_op * mul_op);

    assign radicand = sqx_reg + prod_reg;

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + {{(pperim_pkg::SUM_W+1-pperim_pkg::ROOT_W){1'b0}}, root};
    assign sum_sat  = sum_wide[pperim_pkg::SUM_W] ? pperim_pkg::SUM_MAX
                                                  : sum_wide[pperim_pkg::SUM_W-1:0];

    pperim_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_GO),
        .radicand (radicand),
        .root     (root),
        .status   (sq_stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (open_reg) begin
                        state_next = ST_DIFF;
                    end else if (s_tlast) begin
                        state_next = ST_OUT;  // single vertex, zero length
                    end
                end
            end
            ST_DIFF: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_GO;
            ST_GO:   state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_stat.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (closing_reg) begin
                    state_next = ST_OUT;
                end else if (last_reg) begin
                    state_next = ST_DIFF;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            threshold_reg <= '0;
            filter_en_reg <= 1'b1;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            sum_reg       <= '0;
            open_reg      <= 1'b0;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    pperim_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata;
                    pperim_pkg::REG_FILTER_EN: filter_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        last_reg    <= s_tlast;
                        closing_reg <= 1'b0;
                        prev_x_reg  <= in_x;
                        prev_y_reg  <= in_y;
                        // edge from the previous vertex to this one
                        ax_reg      <= prev_x_reg;
                        ay_reg      <= prev_y_reg;
                        bx_reg      <= in_x;
                        by_reg      <= in_y;
                        if (!open_reg) begin
                            first_x_reg <= in_x;
                            first_y_reg <= in_y;
                            sum_reg     <= '0;
                            open_reg    <= 1'b1;
                        end
                    end
                end
                ST_DIFF: begin
                    dx_reg <= diff_x;
                    dy_reg <= diff_y;
                end
                ST_SQX: prod_reg <= mul_out;
                ST_SQY: begin
                    sqx_reg  <= prod_reg;
                    prod_reg <= mul_out;
                end
                ST_ACC: begin
                    sum_reg <= sum_sat;
                    if (!closing_reg && last_reg) begin
                        // closing edge back to the first vertex
                        closing_reg <= 1'b1;
                        ax_reg      <= prev_x_reg;
                        ay_reg      <= prev_y_reg;
                        bx_reg      <= first_x_reg;
                        by_reg      <= first_y_reg;
                    end
                end
                default: ;
            endcase

            // result word register, reloaded only once the old word is taken
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg   <= 1'b1;
                perim_reg     <= sum_reg;
                selected_reg  <= !filter_en_reg || (sum_reg > threshold_reg);
                saturated_reg <= (sum_reg == pperim_pkg::SUM_MAX);
                first_x_reg   <= '0;
                first_y_reg   <= '0;
                prev_x_reg    <= '0;
                prev_y_reg    <= '0;
                sum_reg       <= '0;
                open_reg      <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pperim_pkg::OUT_DATA_W-pperim_pkg::SUM_W){1'b0}}, perim_reg};
    assign m_tuser[pperim_pkg::USER_SELECTED]  = selected_reg;
    assign m_tuser[pperim_pkg::USER_SATURATED] = saturated_reg;

    a_root_done_in_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_stat.done |-> (state_reg == ST_SQRT))
        else $error("root finished outside the root state");

    a_root_busy_after_go: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GO) |=> sq_stat.busy)
        else $error("root unit idle after start");

    a_closed_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (sum_reg == '0))
        else $error("sum left over with no polygon open");

    a_word_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word loaded outside the output state");

    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (saturated_reg == (perim_reg == pperim_pkg::SUM_MAX)))
        else $error("saturated flag disagrees with perimeter");

endmodule

### tb/testbench.sv
// self-checking testbench for the polygon perimeter filter top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // wait after the last result before a register write or the end of the run
    localparam int SETTLE_CYCLES  = 60;
    // watchdog, several times the slowest correct run
    localparam int CYCLE_LIMIT    = 1_000_000;
    // random vertices in each phase
    localparam int PHASE_VERTICES = 50;
    // enough maximum-length edges to push the sum past 2^27 - 1
    localparam int SAT_VERTICES   = 1460;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [pperim_pkg::CFG_ADDR_W-1:0]    cfg_addr  = '0;
    logic [pperim_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [pperim_pkg::IN_DATA_W-1:0]     s_tdata   = '0;   // vertex_x, vertex_y
    logic                                 s_tlast   = 1'b0; // last_vertex
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [pperim_pkg::OUT_DATA_W-1:0]    m_tdata;          // perimeter, zero pad
    logic [pperim_pkg::OUT_USER_W-1:0]    m_tuser;          // selected, saturated

    // one expected result word
    typedef struct {
        logic [pperim_pkg::SUM_W-1:0] perimeter;
        logic                         selected;
        logic                         saturated;
    } perimeter_word_t;

    perimeter_word_t pending_perimeters[$];

    // local copy of the block's registers and polygon state
    logic [pperim_pkg::SUM_W-1:0]          threshold    = '0;
    logic                                  filter_en    = 1'b1;
    logic signed [pperim_pkg::COORD_W-1:0] first_x      = '0;
    logic signed [pperim_pkg::COORD_W-1:0] first_y      = '0;
    logic signed [pperim_pkg::COORD_W-1:0] prev_x       = '0;
    logic signed [pperim_pkg::COORD_W-1:0] prev_y       = '0;
    logic [pperim_pkg::SUM_W-1:0]          running_sum  = '0;
    bit                                    polygon_open = 1'b0;

    // idling controls, percent of cycles
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int error_count        = 0;
    int cycle_count        = 0;
    int vertices_sent      = 0;
    int perimeters_checked = 0;
    int selected_seen      = 0;
    int saturated_seen     = 0;

    polygon_perimeter_filter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // floor square root of dx*dx + dy*dy, bit by bit from the top
    function automatic logic [pperim_pkg::SUM_W-1:0] edge_length(
        input logic signed [pperim_pkg::COORD_W-1:0] ax, ay, bx, by
    );
        longint          dx;
        longint          dy;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        radicand = dx * dx + dy * dy;
        root = 0;
        for (int b = pperim_pkg::ROOT_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) root = trial;
        end
        return root[pperim_pkg::SUM_W-1:0];
    endfunction

    // sum sticks at its maximum once it would overflow
    function automatic void add_edge(input logic signed [pperim_pkg::COORD_W-1:0] ax, ay,
                                                                                bx, by);
        longint unsigned total;
        total = longint'(running_sum) + longint'(edge_length(ax, ay, bx, by));
        running_sum = (total > pperim_pkg::SUM_MAX) ? pperim_pkg::SUM_MAX
                                                    : total[pperim_pkg::SUM_W-1:0];
    endfunction

    // advance the perimeter state by one accepted vertex
    function automatic void track_vertex(input logic signed [pperim_pkg::COORD_W-1:0] x, y,
                                         input logic last);
        perimeter_word_t word;
        if (!polygon_open) begin
            first_x      = x;
            first_y      = y;
            running_sum  = '0;
            polygon_open = 1'b1;
        end else begin
            add_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (last) begin
            // closing edge back to the first vertex
            add_edge(x, y, first_x, first_y);
            word.perimeter = running_sum;
            word.selected  = !filter_en || (running_sum > threshold);
            word.saturated = (running_sum == pperim_pkg::SUM_MAX);
            pending_perimeters.push_back(word);
            first_x      = '0;
            first_y      = '0;
            prev_x       = '0;
            prev_y       = '0;
            running_sum  = '0;
            polygon_open = 1'b0;
        end
    endfunction

    // offer one vertex word, wait for the handshake, then predict
    // tvalid stays high on return so back-to-back words need no second assignment
    task automatic send_vertex(input logic signed [pperim_pkg::COORD_W-1:0] x, y,
                               input logic last);
        int gap;
        gap = 0;
        if (sender_idle_pct > 0) begin
            // mostly short per-cycle gaps, now and then a long pause
            if ($urandom_range(15) == 0)
                gap = $urandom_range(60);
            else
                while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_vertex(x, y, last);
        vertices_sent++;
    endtask

    // stop offering words, wait for every result, then let the block go idle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_perimeters.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [pperim_pkg::CFG_ADDR_W-1:0] index,
                                  input logic [pperim_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == pperim_pkg::REG_THRESHOLD)
            threshold = value;
        else if (index == pperim_pkg::REG_FILTER_EN)
            filter_en = value[0];
        @(posedge aclk);
    endtask

    // both registers, only once the block has nothing in flight
    task automatic configure(input logic [pperim_pkg::SUM_W-1:0] thr, input logic en);
        drain_results();
        write_register(pperim_pkg::REG_THRESHOLD, thr);
        // junk above bit 0 must be ignored
        write_register(pperim_pkg::REG_FILTER_EN,
                       {(pperim_pkg::CFG_DATA_W-1)'($urandom), en});
    endtask

    function automatic logic signed [pperim_pkg::COORD_W-1:0] extreme_coord();
        case ($urandom_range(4))
            0: return {1'b1, {(pperim_pkg::COORD_W-1){1'b0}}};
            1: return {1'b0, {(pperim_pkg::COORD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return pperim_pkg::COORD_W'(1);
        endcase
    endfunction

    task automatic random_polygon(input int n_vertices);
        logic signed [pperim_pkg::COORD_W-1:0] x;
        logic signed [pperim_pkg::COORD_W-1:0] y;
        int style;
        style = $urandom_range(3);
        x = pperim_pkg::COORD_W'($urandom);
        y = pperim_pkg::COORD_W'($urandom);
        for (int v = 0; v < n_vertices; v++) begin
            case (style)
                0: begin
                    x = pperim_pkg::COORD_W'($urandom);
                    y = pperim_pkg::COORD_W'($urandom);
                end
                1: begin
                    // short steps, wrapping freely
                    x = x + pperim_pkg::COORD_W'($urandom_range(64)) - pperim_pkg::COORD_W'(32);
                    y = y + pperim_pkg::COORD_W'($urandom_range(64)) - pperim_pkg::COORD_W'(32);
                end
                2: begin
                    x = extreme_coord();
                    y = extreme_coord();
                end
                default: begin
                    x = pperim_pkg::COORD_W'($urandom_range(512)) - pperim_pkg::COORD_W'(256);
                    y = pperim_pkg::COORD_W'($urandom_range(512)) - pperim_pkg::COORD_W'(256);
                end
            endcase
            send_vertex(x, y, v == n_vertices - 1);
        end
    endtask

    // single-vertex polygons under reset settings: perimeter 0, not above 0
    task automatic test_single_vertex();
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    endtask

    // full-range diagonals, axis edges and a repeated vertex
    task automatic test_extreme_edges();
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b1);

        send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b1);

        send_vertex(16'sh8000, 16'sd0, 1'b0);
        send_vertex(16'sh7fff, 16'sd0, 1'b0);
        send_vertex(16'sh7fff, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sh8000, 1'b1);
    endtask

    task automatic unit_square();
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd16, 16'sd0, 1'b0);
        send_vertex(16'sd16, 16'sd16, 1'b0);
        send_vertex(16'sd0, 16'sd16, 1'b1);
    endtask

    // unit square has perimeter 64: equal is not above, one less is; filter off selects it
    task automatic test_threshold_compare();
        configure(pperim_pkg::SUM_W'(64), 1'b1);
        unit_square();
        configure(pperim_pkg::SUM_W'(63), 1'b1);
        unit_square();
        configure(pperim_pkg::SUM_MAX, 1'b0);
        unit_square();
    endtask

    // long zigzag between opposite corners until the sum sticks
    task automatic test_sum_saturation();
        configure(pperim_pkg::SUM_MAX, 1'b1);
        for (int v = 0; v < SAT_VERTICES; v++) begin
            if (v % 2 == 0)
                send_vertex(16'sh8000, 16'sh8000, v == SAT_VERTICES - 1);
            else
                send_vertex(16'sh7fff, 16'sh7fff, v == SAT_VERTICES - 1);
        end
    endtask

    // four phases, each with its own register settings; idling in phases 1 to 3
    task automatic test_random_polygons();
        int start;
        int n;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: configure(pperim_pkg::SUM_W'($urandom_range(400000)), 1'b1);
                1: configure(pperim_pkg::SUM_W'($urandom), 1'b0);
                2: configure('0, 1'b1);
                default: configure(pperim_pkg::SUM_W'($urandom_range(300000)), 1'b1);
            endcase
            sender_idle_pct    = (phase == 1) ? 69 : (phase == 3) ? 13 : 0;
            receiver_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 13 : 0;
            start = vertices_sent;
            while (vertices_sent - start < PHASE_VERTICES) begin
                if ($urandom_range(99) < 8)
                    n = 1;
                else if ($urandom_range(99) < 75)
                    n = $urandom_range(2, 6);
                else
                    n = $urandom_range(7, 24);
                random_polygon(n);
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // result checker and receiver back-pressure
    always @(posedge aclk) begin : check_results
        perimeter_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_perimeters.size() == 0) begin
                $error("result word with nothing pending: tdata %h tuser %b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_perimeters.pop_front();
                if (m_tdata[pperim_pkg::SUM_W-1:0] !== want.perimeter) begin
                    $error("perimeter: expected %0d, got %0d", want.perimeter,
                           m_tdata[pperim_pkg::SUM_W-1:0]);
                    error_count++;
                end
                if (m_tdata[pperim_pkg::OUT_DATA_W-1:pperim_pkg::SUM_W] !== '0) begin
                    $error("tdata pad: expected 0, got %h",
                           m_tdata[pperim_pkg::OUT_DATA_W-1:pperim_pkg::SUM_W]);
                    error_count++;
                end
                if (m_tuser[pperim_pkg::USER_SELECTED] !== want.selected) begin
                    $error("selected: expected %b, got %b", want.selected,
                           m_tuser[pperim_pkg::USER_SELECTED]);
                    error_count++;
                end
                if (m_tuser[pperim_pkg::USER_SATURATED] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated,
                           m_tuser[pperim_pkg::USER_SATURATED]);
                    error_count++;
                end
                perimeters_checked++;
                if (want.selected) selected_seen++;
                if (want.saturated) saturated_seen++;
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: no progress after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        // synchronous reset, released before the first test
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_vertex();
        test_extreme_edges();
        test_threshold_compare();
        test_sum_saturation();
        test_random_polygons();

        drain_results();
        $display("testbench: %0d vertices sent, %0d perimeters checked (%0d selected, %0d saturated)",
                 vertices_sent, perimeters_checked, selected_seen, saturated_seen);
        $display("testbench: threshold and filter settings swept, idling on each side in turn");
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
